// ----- rtl/bgm_pkg.sv -----
// Shared types, curve tables and register codes for the battery gauge monitor.
package bgm_pkg;

  localparam int MV_W   = 13;
  localparam int PCT_W  = 7;
  localparam int NUM_W  = 15;
  localparam int DEN_W  = 9;
  localparam int SEG_W  = 4;
  localparam int CNT_W  = 4;
  localparam int DP_W   = 5;
  localparam int DV_W   = 8;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int NUM_POINTS = 9;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CUTOFF    = 2'd0;
  localparam logic [1:0] REG_LOW_LIMIT = 2'd1;
  localparam logic [1:0] REG_IND_PCT   = 2'd2;
  localparam logic [1:0] REG_BLINK_PCT = 2'd3;

  // Curve break points in millivolts.
  localparam logic [MV_W-1:0] CURVE_MV [NUM_POINTS] = '{
    13'd3350, 13'd3550, 13'd3680, 13'd3740, 13'd3800,
    13'd3880, 13'd3960, 13'd4060, 13'd4180
  };

  // Per segment ending at point s: 2*p0*dv + dv, the constant part of the
  // rounding numerator.
  localparam logic [NUM_W-1:0] SEG_BASE [NUM_POINTS] = '{
    15'd0, 15'd200, 15'd1430, 15'd1500, 15'd2700,
    15'd5520, 15'd7760, 15'd12900, 15'd19800
  };

  // Per segment: 2*dv, the divisor.
  localparam logic [DEN_W-1:0] SEG_DEN [NUM_POINTS] = '{
    9'd0, 9'd400, 9'd260, 9'd120, 9'd120,
    9'd160, 9'd160, 9'd200, 9'd240
  };

  // Per segment: percent rise across the segment.
  localparam logic [DP_W-1:0] SEG_DP [NUM_POINTS] = '{
    5'd0, 5'd5, 5'd7, 5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd18
  };

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } bgm_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
  } bgm_div_rsp_t;

endpackage

// ----- rtl/battery_gauge_low_battery_monitor.sv -----
// Top level: sample to percent mapping, low-run counter, icon and poll logic.
// For a voltage inside the curve a sample passes through map, 15 divider steps,
// pick and output before out_valid rises; otherwise it goes from map to output.
// No new sample is taken before the last one enters the output register.
// Reset (rst_n, synchronous, active low) restores the register defaults,
// clears the low-run count and sets the blink phase to visible.
module battery_gauge_low_battery_monitor
  import bgm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MV_W-1:0]   in_voltage_mv,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_percent_valid,
  output logic [PCT_W-1:0]  out_charge_percent,
  output logic              out_icon_visible,
  output logic              out_fast_poll,
  output logic              out_shutdown_request,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [1:0] {S_IDLE, S_MAP, S_DIV, S_DONE} state_t;

  state_t           state_r, state_nxt;

  // Configuration registers.
  logic [MV_W-1:0]  cutoff_r, cutoff_nxt;
  logic [CNT_W-1:0] limit_r, limit_nxt;
  logic [PCT_W-1:0] ind_pct_r, ind_pct_nxt;
  logic [PCT_W-1:0] blink_pct_r, blink_pct_nxt;

  // Block state that carries from one item to the next.
  logic [CNT_W-1:0] run_cnt_r, run_cnt_nxt;
  logic             phase_r, phase_nxt;

  // Item being worked on.
  logic [MV_W-1:0]  volt_r, volt_nxt;
  logic [PCT_W-1:0] pct_r, pct_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic             o_pv_r, o_pv_nxt;
  logic [PCT_W-1:0] o_pct_r, o_pct_nxt;
  logic             o_vis_r, o_vis_nxt;
  logic             o_fast_r, o_fast_nxt;
  logic             o_shut_r, o_shut_nxt;

  bgm_div_req_t     div_req;
  bgm_div_rsp_t     div_rsp;

  // Segment lookup signals.
  logic [SEG_W-1:0] seg;
  logic [SEG_W-1:0] seg_m1;
  logic [MV_W-1:0]  seg_ofs;
  logic [MV_W-1:0]  prod;
  logic             below_curve;
  logic             above_curve;

  // Finish-step signals.
  logic             item_ok;
  logic             is_low;
  logic [CNT_W:0]   cnt_inc;
  logic [CNT_W-1:0] cnt_sat;
  logic             cfg_wr;
  logic             out_free;

  assign cfg_wr   = psel & penable & pwrite;
  assign pready   = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_CUTOFF:    prdata = DATA_W'(cutoff_r);
      REG_LOW_LIMIT: prdata = DATA_W'(limit_r);
      REG_IND_PCT:   prdata = DATA_W'(ind_pct_r);
      REG_BLINK_PCT: prdata = DATA_W'(blink_pct_r);
      default:       prdata = '0;
    endcase
  end

  // Find the curve segment whose upper point is the first one at or above
  // the sample, then form the rounding numerator for the divider.
  always_comb begin
    seg = SEG_W'(NUM_POINTS - 1);
    for (int k = NUM_POINTS - 1; k >= 1; k--) begin
      if (volt_r <= CURVE_MV[k]) begin
        seg = SEG_W'(k);
      end
    end
    seg_m1      = seg - 1'b1;
    below_curve = (volt_r <= CURVE_MV[0]);
    above_curve = (volt_r > CURVE_MV[NUM_POINTS-1]);
    seg_ofs     = volt_r - CURVE_MV[seg_m1];
    prod        = MV_W'(SEG_DP[seg]) * MV_W'(seg_ofs[DV_W-1:0]);
    div_req.num = SEG_BASE[seg] + NUM_W'({prod, 1'b0});
    div_req.den = SEG_DEN[seg];
    div_req.start = (state_r == S_MAP) && (volt_r != '0) && !below_curve && !above_curve;
  end

  bgm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer and state updates.
  always_comb begin
    state_nxt     = state_r;
    cutoff_nxt    = cutoff_r;
    limit_nxt     = limit_r;
    ind_pct_nxt   = ind_pct_r;
    blink_pct_nxt = blink_pct_r;
    run_cnt_nxt   = run_cnt_r;
    phase_nxt     = phase_r;
    volt_nxt      = volt_r;
    pct_nxt       = pct_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_pv_nxt      = o_pv_r;
    o_pct_nxt     = o_pct_r;
    o_vis_nxt     = o_vis_r;
    o_fast_nxt    = o_fast_r;
    o_shut_nxt    = o_shut_r;

    item_ok = (volt_r != '0);
    is_low  = item_ok && (volt_r <= cutoff_r);
    cnt_inc = {1'b0, run_cnt_r} + 1'b1;
    cnt_sat = (cnt_inc > {1'b0, limit_r}) ? limit_r : cnt_inc[CNT_W-1:0];

    if (cfg_wr) begin
      case (paddr[3:2])
        REG_CUTOFF:    cutoff_nxt    = pwdata[MV_W-1:0];
        REG_LOW_LIMIT: limit_nxt     = pwdata[CNT_W-1:0];
        REG_IND_PCT:   ind_pct_nxt   = pwdata[PCT_W-1:0];
        REG_BLINK_PCT: blink_pct_nxt = pwdata[PCT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          volt_nxt  = in_voltage_mv;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        // Invalid samples and samples off either end of the curve need no
        // division.
        if (div_req.start) begin
          state_nxt = S_DIV;
        end else begin
          pct_nxt   = (item_ok && above_curve) ? PCT_MAX : '0;
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          pct_nxt   = (div_rsp.quo > NUM_W'(PCT_MAX)) ? PCT_MAX : div_rsp.quo[PCT_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_pv_nxt      = item_ok;
          o_pct_nxt     = pct_r;
          o_shut_nxt    = 1'b0;
          if (is_low) begin
            run_cnt_nxt = cnt_sat;
            o_shut_nxt  = (cnt_sat >= limit_r);
          end else if (item_ok) begin
            run_cnt_nxt = '0;
          end
          // Icon: hidden for an invalid sample or at or above the indicator threshold,
          // steady between the thresholds, and blinking below the blink threshold.
          if (!item_ok || pct_r >= ind_pct_r) begin
            phase_nxt  = 1'b1;
            o_vis_nxt  = 1'b0;
            o_fast_nxt = 1'b0;
          end else if (pct_r >= blink_pct_r) begin
            phase_nxt  = 1'b1;
            o_vis_nxt  = 1'b1;
            o_fast_nxt = 1'b1;
          end else begin
            phase_nxt  = !phase_r;
            o_vis_nxt  = phase_r;
            o_fast_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    volt_r   <= volt_nxt;
    pct_r    <= pct_nxt;
    o_pv_r   <= o_pv_nxt;
    o_pct_r  <= o_pct_nxt;
    o_vis_r  <= o_vis_nxt;
    o_fast_r <= o_fast_nxt;
    o_shut_r <= o_shut_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cutoff_r    <= 13'd3300;
      limit_r     <= 4'd3;
      ind_pct_r   <= 7'd20;
      blink_pct_r <= 7'd10;
      run_cnt_r   <= '0;
      phase_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cutoff_r    <= cutoff_nxt;
      limit_r     <= limit_nxt;
      ind_pct_r   <= ind_pct_nxt;
      blink_pct_r <= blink_pct_nxt;
      run_cnt_r   <= run_cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_percent_valid    = o_pv_r;
  assign out_charge_percent   = o_pct_r;
  assign out_icon_visible     = o_vis_r;
  assign out_fast_poll        = o_fast_r;
  assign out_shutdown_request = o_shut_r;

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  // A result never reports more than full charge.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_charge_percent <= PCT_MAX)
    else $error("charge percent above full scale");

  // Shutdown is only requested for a valid sample.
  a_shut_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shutdown_request |-> out_percent_valid)
    else $error("shutdown requested on an invalid sample");

  // The icon is only shown while the fast poll period is selected.
  a_icon_fast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_icon_visible |-> out_fast_poll)
    else $error("icon shown with slow poll period");

endmodule

// ----- rtl/bgm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module bgm_div
  import bgm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  bgm_div_req_t req,
  output bgm_div_rsp_t rsp
);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    fits     = (trial >= {1'b0, den_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
